// ===== rtl/utf8_filename_sanitizer_assert.svh =====
// Assertion macros shared by the filename sanitizer modules.
`ifndef UTF8_FILENAME_SANITIZER_ASSERT_SVH
`define UTF8_FILENAME_SANITIZER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define UFS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define UFS_ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ===== rtl/ufs_pkg.sv =====
// Shared constants, types and code point functions of the filename sanitizer.
`default_nettype none

package ufs_pkg;

    localparam int HOLD_DEPTH_DEF = 16;
    localparam int MAX_RES        = 32;
    localparam int RES_W          = $clog2(MAX_RES + 1);

    localparam logic [20:0] CP_REPL   = 21'h00FFFD;
    localparam logic [20:0] CP_SPACE  = 21'h000020;
    localparam logic [20:0] CP_DOT    = 21'h00002E;
    localparam logic [20:0] CP_UNDER  = 21'h00005F;
    localparam logic [20:0] CP_SLASH  = 21'h00002F;
    localparam logic [20:0] CP_BSLASH = 21'h00005C;
    localparam logic [20:0] CP_COLON  = 21'h00003A;
    localparam logic [20:0] CP_STAR   = 21'h00002A;
    localparam logic [20:0] CP_QUEST  = 21'h00003F;
    localparam logic [20:0] CP_QUOTE  = 21'h000022;
    localparam logic [20:0] CP_LT     = 21'h00003C;
    localparam logic [20:0] CP_GT     = 21'h00003E;
    localparam logic [20:0] CP_PIPE   = 21'h00007C;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2      = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3      = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4      = 8'hF0;
    localparam logic [7:0] CONT       = 8'h80;

    localparam logic [1:0] PSRC_HELD   = 2'd0;
    localparam logic [1:0] PSRC_ENC    = 2'd1;
    localparam logic [1:0] PSRC_STATUS = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       absorb;
        logic       start;
        logic       repl_step;
        logic       pend_clear;
        logic       set_ovf;
        logic       flush_done;
        logic       hold_add;
        logic       push;
        logic [1:0] psrc;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic pend;
        logic cont;
        logic complete;
        logic start_emits;
        logic last;
        logic drop;
        logic spdot;
        logic emitted_any;
        logic hold_full;
        logic flush_more;
        logic enc_last;
        logic can_push;
        logic stg_valid;
    } t_sts;

    function automatic logic [20:0] map_cp(input logic [20:0] cp);
        logic [20:0] m;
        case (cp) inside
            CP_SLASH, CP_BSLASH, CP_COLON, CP_STAR, CP_QUEST,
            CP_QUOTE, CP_LT, CP_GT, CP_PIPE: m = CP_UNDER;
            default: m = cp;
        endcase
        return m;
    endfunction

    function automatic logic is_droppable(input logic [20:0] cp);
        return (cp < 21'h20) || (cp == 21'h7F)
            || (cp >= 21'h80 && cp <= 21'h9F)
            || (cp >= 21'h200B && cp <= 21'h200F)
            || (cp == 21'h2028) || (cp == 21'h2029)
            || (cp == 21'h2060) || (cp == 21'hFEFF)
            || (cp >= 21'hFE00 && cp <= 21'hFE0F)
            || (cp >= 21'h2190 && cp <= 21'h21FF)
            || (cp >= 21'h2300 && cp <= 21'h27BF)
            || (cp >= 21'h2B00 && cp <= 21'h2BFF)
            || (cp >= 21'h1F000 && cp <= 21'h1FAFF);
    endfunction

    function automatic logic [1:0] enc_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h80) begin
            n = 2'd0;
        end else if (cp < 21'h800) begin
            n = 2'd1;
        end else if (cp < 21'h10000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] k);
        logic [7:0] b;
        case (enc_len_m1(cp))
            2'd0: b = cp[7:0];
            2'd1: b = (k == 2'd0) ? (LEAD2 | {3'd0, cp[10:6]}) : (CONT | {2'd0, cp[5:0]});
            2'd2: begin
                case (k)
                    2'd0:    b = LEAD3 | {4'd0, cp[15:12]};
                    2'd1:    b = CONT | {2'd0, cp[11:6]};
                    default: b = CONT | {2'd0, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    2'd0:    b = LEAD4 | {5'd0, cp[20:18]};
                    2'd1:    b = CONT | {2'd0, cp[17:12]};
                    2'd2:    b = CONT | {2'd0, cp[11:6]};
                    default: b = CONT | {2'd0, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ufs_dp.sv =====
// Datapath of the filename sanitizer: decoder state, held run, encoder and output stages.
`default_nettype none
`include "utf8_filename_sanitizer_assert.svh"

module ufs_dp #(
    parameter int HOLD_DEPTH = ufs_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_in_last,
    input  wire ufs_pkg::t_cmd i_cmd,
    output ufs_pkg::t_sts      o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic [3:0]         o_out_user,
    output logic               o_out_last
);

    localparam int HCNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int HIDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    logic [7:0]                r_c;
    logic                      r_last;
    logic [1:0]                r_pend_cnt;
    logic [1:0]                r_exp;
    logic [20:0]               r_partial;
    logic [20:0]               r_cp;
    logic                      r_emitted;
    logic                      r_ovf;
    logic                      r_kinds [HOLD_DEPTH];
    logic [HCNT_W-1:0]         r_held_cnt;
    logic [HCNT_W-1:0]         r_fl_idx;
    logic [1:0]                r_enc_k;
    logic [ufs_pkg::RES_W-1:0] r_res_n;
    logic                      r_stg_valid;
    logic [7:0]                r_stg_byte;
    logic [3:0]                r_stg_user;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic [3:0]                r_out_user;
    logic                      r_out_last;

    logic [20:0] cp_m;
    logic [1:0]  len_m1;
    logic [20:0] new_partial;
    logic        is_lead2;
    logic        is_lead3;
    logic        is_lead4;
    logic        can_push;
    logic        take;
    logic        move;
    logic        push_held;
    logic        push_enc;
    logic        push_status;
    logic        enc_last;
    logic [7:0]  push_byte;
    logic [3:0]  push_user;

    always_comb begin
        cp_m        = ufs_pkg::map_cp(r_cp);
        len_m1      = ufs_pkg::enc_len_m1(cp_m);
        enc_last    = (r_enc_k == len_m1);
        new_partial = {r_partial[14:0], r_c[5:0]};
        is_lead2    = (r_c & ufs_pkg::LEAD2_MASK) == ufs_pkg::LEAD2;
        is_lead3    = (r_c & ufs_pkg::LEAD3_MASK) == ufs_pkg::LEAD3;
        is_lead4    = (r_c & ufs_pkg::LEAD4_MASK) == ufs_pkg::LEAD4;
        can_push    = !r_stg_valid || !r_out_valid || i_out_ready;
        push_held   = i_cmd.push && (i_cmd.psrc == ufs_pkg::PSRC_HELD);
        push_enc    = i_cmd.push && (i_cmd.psrc == ufs_pkg::PSRC_ENC);
        push_status = i_cmd.push && (i_cmd.psrc == ufs_pkg::PSRC_STATUS);
        take        = i_cmd.push && (r_res_n < ufs_pkg::RES_W'(ufs_pkg::MAX_RES));
        move        = (take && r_stg_valid) || i_cmd.finish;
    end

    always_comb begin
        case (i_cmd.psrc)
            ufs_pkg::PSRC_HELD: begin
                push_byte = r_kinds[r_fl_idx[HIDX_W-1:0]] ? ufs_pkg::CH_DOT : ufs_pkg::CH_SPACE;
                push_user = {r_ovf, 1'b0, 1'b0, 1'b1};
            end
            ufs_pkg::PSRC_ENC: begin
                push_byte = ufs_pkg::enc_byte(cp_m, r_enc_k);
                push_user = {r_ovf, 1'b0, 1'b0, 1'b1};
            end
            default: begin
                push_byte = 8'd0;
                push_user = {r_ovf, !r_emitted, 1'b1, 1'b0};
            end
        endcase
    end

    always_comb begin
        o_sts.pend        = (r_pend_cnt != 2'd0);
        o_sts.cont        = (r_c[7:6] == 2'b10);
        o_sts.complete    = (r_pend_cnt >= r_exp);
        o_sts.start_emits = !r_c[7] || !(is_lead2 || is_lead3 || is_lead4);
        o_sts.last        = r_last;
        o_sts.drop        = ufs_pkg::is_droppable(cp_m);
        o_sts.spdot       = (cp_m == ufs_pkg::CP_SPACE) || (cp_m == ufs_pkg::CP_DOT);
        o_sts.emitted_any = r_emitted;
        o_sts.hold_full   = (r_held_cnt >= HCNT_W'(HOLD_DEPTH));
        o_sts.flush_more  = (r_fl_idx < r_held_cnt);
        o_sts.enc_last    = enc_last;
        o_sts.can_push    = can_push;
        o_sts.stg_valid   = r_stg_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_c    <= i_in_byte;
            r_last <= i_in_last;
        end
        if (i_cmd.absorb && (r_pend_cnt >= r_exp)) begin
            r_cp <= new_partial;
        end else if (i_cmd.start) begin
            if (!r_c[7]) begin
                r_cp <= {13'd0, r_c};
            end else if (!(is_lead2 || is_lead3 || is_lead4)) begin
                r_cp <= ufs_pkg::CP_REPL;
            end
        end else if (i_cmd.repl_step) begin
            r_cp <= ufs_pkg::CP_REPL;
        end
        if (i_cmd.hold_add) begin
            r_kinds[r_held_cnt[HIDX_W-1:0]] <= (cp_m == ufs_pkg::CP_DOT);
        end
        if (take) begin
            r_stg_byte <= push_byte;
            r_stg_user <= push_user;
        end
        if (move) begin
            r_out_byte <= r_stg_byte;
            r_out_user <= r_stg_user;
            r_out_last <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_exp      <= '0;
            r_partial  <= '0;
        end else if (i_cmd.absorb) begin
            if (r_pend_cnt >= r_exp) begin
                r_pend_cnt <= '0;
                r_exp      <= '0;
                r_partial  <= '0;
            end else begin
                r_partial  <= new_partial;
                r_pend_cnt <= r_pend_cnt + 2'd1;
            end
        end else if (i_cmd.start && r_c[7]) begin
            if (is_lead2) begin
                r_exp      <= 2'd1;
                r_partial  <= {16'd0, r_c[4:0]};
                r_pend_cnt <= 2'd1;
            end else if (is_lead3) begin
                r_exp      <= 2'd2;
                r_partial  <= {17'd0, r_c[3:0]};
                r_pend_cnt <= 2'd1;
            end else if (is_lead4) begin
                r_exp      <= 2'd3;
                r_partial  <= {18'd0, r_c[2:0]};
                r_pend_cnt <= 2'd1;
            end
        end else if (i_cmd.repl_step) begin
            r_pend_cnt <= r_pend_cnt - 2'd1;
        end else if (i_cmd.pend_clear) begin
            r_exp     <= '0;
            r_partial <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted  <= 1'b0;
            r_ovf      <= 1'b0;
            r_held_cnt <= '0;
            r_fl_idx   <= '0;
            r_enc_k    <= '0;
        end else begin
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (push_held) begin
                r_fl_idx <= r_fl_idx + HCNT_W'(1);
            end
            if (i_cmd.flush_done) begin
                r_fl_idx   <= '0;
                r_held_cnt <= '0;
            end
            if (i_cmd.hold_add) begin
                r_held_cnt <= r_held_cnt + HCNT_W'(1);
            end
            if (push_enc) begin
                r_emitted <= 1'b1;
                r_enc_k   <= enc_last ? 2'd0 : r_enc_k + 2'd1;
            end
            if (push_status) begin
                r_held_cnt <= '0;
                r_emitted  <= 1'b0;
                r_ovf      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_n     <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_res_n <= '0;
            end else if (take) begin
                r_res_n <= r_res_n + ufs_pkg::RES_W'(1);
            end
            if (take) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_stg_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    `UFS_ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, r_held_cnt <= HCNT_W'(HOLD_DEPTH), "held run beyond depth")
    `UFS_ASSERT_IMPL(a_pend_has_len, i_clk, i_rst_n, r_pend_cnt != 2'd0, r_exp != 2'd0, "pending bytes without length")
    `UFS_ASSERT_IMPL(a_stg_counted, i_clk, i_rst_n, r_stg_valid, r_res_n != '0, "staged result not counted")

endmodule

`default_nettype wire

// ===== rtl/ufs_ctrl.sv =====
// Controller state machine of the filename sanitizer.
`default_nettype none
`include "utf8_filename_sanitizer_assert.svh"

module ufs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ufs_pkg::t_sts i_sts,
    output ufs_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLASSIFY = 4'd1;
    localparam logic [3:0] S_ABANDON  = 4'd2;
    localparam logic [3:0] S_START    = 4'd3;
    localparam logic [3:0] S_TAIL     = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_FLUSH    = 4'd6;
    localparam logic [3:0] S_HOLD     = 4'd7;
    localparam logic [3:0] S_ENC      = 4'd8;
    localparam logic [3:0] S_STATUS   = 4'd9;
    localparam logic [3:0] S_END      = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] r_emit_ret;
    logic [3:0] n_emit_ret;
    logic [3:0] r_flush_ret;
    logic [3:0] n_flush_ret;
    logic       r_final;
    logic       n_final;

    always_comb begin
        n_state     = r_state;
        n_emit_ret  = r_emit_ret;
        n_flush_ret = r_flush_ret;
        n_final     = r_final;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_sts.pend && i_sts.cont) begin
                    o_cmd.absorb = 1'b1;
                    if (i_sts.complete) begin
                        n_emit_ret = S_TAIL;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_TAIL;
                    end
                end else if (i_sts.pend) begin
                    n_final = 1'b0;
                    n_state = S_ABANDON;
                end else begin
                    n_state = S_START;
                end
            end
            S_ABANDON: begin
                if (i_sts.pend) begin
                    o_cmd.repl_step = 1'b1;
                    n_emit_ret      = S_ABANDON;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.pend_clear = 1'b1;
                    n_state          = r_final ? S_STATUS : S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                if (i_sts.start_emits) begin
                    n_emit_ret = S_TAIL;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_sts.last) begin
                    n_final = 1'b1;
                    n_state = S_ABANDON;
                end else begin
                    n_state = S_END;
                end
            end
            S_EMIT: begin
                if (i_sts.drop || (i_sts.spdot && !i_sts.emitted_any)) begin
                    n_state = r_emit_ret;
                end else if (i_sts.spdot) begin
                    if (i_sts.hold_full) begin
                        o_cmd.set_ovf = 1'b1;
                        n_flush_ret   = S_HOLD;
                        n_state       = S_FLUSH;
                    end else begin
                        n_state = S_HOLD;
                    end
                end else begin
                    n_flush_ret = S_ENC;
                    n_state     = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.flush_more) begin
                    if (i_sts.can_push) begin
                        o_cmd.push = 1'b1;
                        o_cmd.psrc = ufs_pkg::PSRC_HELD;
                    end
                end else begin
                    o_cmd.flush_done = 1'b1;
                    n_state          = r_flush_ret;
                end
            end
            S_HOLD: begin
                o_cmd.hold_add = 1'b1;
                n_state        = r_emit_ret;
            end
            S_ENC: begin
                if (i_sts.can_push) begin
                    o_cmd.push = 1'b1;
                    o_cmd.psrc = ufs_pkg::PSRC_ENC;
                    if (i_sts.enc_last) begin
                        n_state = r_emit_ret;
                    end
                end
            end
            S_STATUS: begin
                if (i_sts.can_push) begin
                    o_cmd.push = 1'b1;
                    o_cmd.psrc = ufs_pkg::PSRC_STATUS;
                    n_state    = S_END;
                end
            end
            S_END: begin
                if (!i_sts.stg_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.can_push) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit_ret  <= S_TAIL;
            r_flush_ret <= S_ENC;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit_ret  <= n_emit_ret;
            r_flush_ret <= n_flush_ret;
            r_final     <= n_final;
        end
    end

    `UFS_ASSERT_IMPL(a_idle_stg_empty, i_clk, i_rst_n, r_state == S_IDLE, !i_sts.stg_valid, "result left staged at idle")
    `UFS_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, o_cmd.push || o_cmd.finish, i_sts.can_push, "push without room")

endmodule

`default_nettype wire

// ===== rtl/utf8_filename_sanitizer.sv =====
// Top level of the streaming UTF-8 filename sanitizer.
// A request is taken in idle, and its results pass through the staging register into the output
// register; the last result of each request leaves staging in the final step.
// A new request is taken only once the previous one is fully processed: pushing each result,
// replacing each abandoned byte and closing each abandon pass; output stalls hold it back.
// Reset: i_rst_n synchronous, active low; clears the decoder, held run and output valid.
`default_nettype none

module utf8_filename_sanitizer #(
    parameter int HOLD_DEPTH = ufs_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,  // [7:0] in_byte
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,  // [7:0] out_byte
    output logic [3:0]      o_m_tuser,  // [0] byte_valid, [1] name_done, [2] name_empty,
                                        // [3] hold_overflow
    output logic            o_m_tlast
);

    ufs_pkg::t_cmd cmd;
    ufs_pkg::t_sts sts;

    ufs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ufs_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_s_tdata),
        .i_in_last   (i_s_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_user  (o_m_tuser),
        .o_out_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/utf8_filename_sanitizer_checker.sv =====
// Checker for the filename sanitizer: predicts cleaned bytes per request and compares them.
module utf8_filename_sanitizer_checker #(
    parameter int HOLD_DEPTH = ufs_pkg::HOLD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic [3:0] i_m_tuser,
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       ok;
        logic       run_end;
        logic       done;
        logic       empty;
        logic       ovf;
    } t_clean;

    t_clean      step_q[$];
    t_clean      clean_q[$];

    logic [1:0]  seq_have;
    logic [1:0]  seq_need;
    logic [20:0] seq_cp;
    logic        name_started;
    logic        dot_kind[HOLD_DEPTH];
    int          held_len;
    logic        ovf_flag;

    task automatic put_result(input logic [7:0] ch, input logic ok, input logic done,
                              input logic empty);
        t_clean r;
        if (step_q.size() < ufs_pkg::MAX_RES) begin
            r.ch      = ch;
            r.ok      = ok;
            r.run_end = 1'b0;
            r.done    = done;
            r.empty   = empty;
            r.ovf     = ovf_flag;
            step_q    = {step_q, r};
        end
    endtask

    task automatic release_held();
        for (int k = 0; k < held_len && k < HOLD_DEPTH; k++) begin
            put_result(dot_kind[k] ? ufs_pkg::CH_DOT : ufs_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0);
        end
        held_len = 0;
    endtask

    function automatic logic stripped(input logic [20:0] cp);
        return (cp < 21'h20) || (cp == 21'h7F)
            || (cp >= 21'h80 && cp <= 21'h9F)
            || (cp >= 21'h200B && cp <= 21'h200F)
            || (cp == 21'h2028) || (cp == 21'h2029)
            || (cp == 21'h2060) || (cp == 21'hFEFF)
            || (cp >= 21'hFE00 && cp <= 21'hFE0F)
            || (cp >= 21'h2190 && cp <= 21'h21FF)
            || (cp >= 21'h2300 && cp <= 21'h27BF)
            || (cp >= 21'h2B00 && cp <= 21'h2BFF)
            || (cp >= 21'h1F000 && cp <= 21'h1FAFF);
    endfunction

    task automatic clean_codepoint(input logic [20:0] cp);
        logic [20:0] c;
        c = cp;
        case (c) inside
            ufs_pkg::CP_SLASH, ufs_pkg::CP_BSLASH, ufs_pkg::CP_COLON,
            ufs_pkg::CP_STAR, ufs_pkg::CP_QUEST, ufs_pkg::CP_QUOTE,
            ufs_pkg::CP_LT, ufs_pkg::CP_GT, ufs_pkg::CP_PIPE: c = ufs_pkg::CP_UNDER;
            default: ;
        endcase
        if (stripped(c)) begin
            return;
        end
        if (c == ufs_pkg::CP_SPACE || c == ufs_pkg::CP_DOT) begin
            if (!name_started) begin
                return;
            end
            if (held_len >= HOLD_DEPTH) begin
                ovf_flag = 1'b1;
                release_held();
            end
            dot_kind[held_len] = (c == ufs_pkg::CP_DOT);
            held_len++;
            return;
        end
        release_held();
        name_started = 1'b1;
        if (c < 21'h80) begin
            put_result(c[7:0], 1'b1, 1'b0, 1'b0);
        end else if (c < 21'h800) begin
            put_result({3'b110, c[10:6]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[5:0]}, 1'b1, 1'b0, 1'b0);
        end else if (c < 21'h10000) begin
            put_result({4'b1110, c[15:12]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[11:6]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[5:0]}, 1'b1, 1'b0, 1'b0);
        end else begin
            put_result({5'b11110, c[20:18]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[17:12]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[11:6]}, 1'b1, 1'b0, 1'b0);
            put_result({2'b10, c[5:0]}, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic abandon_seq();
        for (int k = 0; k < seq_have; k++) begin
            clean_codepoint(ufs_pkg::CP_REPL);
        end
        seq_have = 2'd0;
        seq_need = 2'd0;
        seq_cp   = '0;
    endtask

    task automatic open_seq(input logic [7:0] b);
        if (!b[7]) begin
            clean_codepoint({13'd0, b});
            return;
        end
        if (b[7:5] == 3'b110) begin
            seq_need = 2'd1;
            seq_cp   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            seq_need = 2'd2;
            seq_cp   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            seq_need = 2'd3;
            seq_cp   = {18'd0, b[2:0]};
        end else begin
            clean_codepoint(ufs_pkg::CP_REPL);
            return;
        end
        seq_have = 2'd1;
    endtask

    task automatic sanitize_step(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        step_q.delete();
        if (seq_have != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                seq_cp = {seq_cp[14:0], b[5:0]};
                if (seq_have >= seq_need) begin
                    cp       = seq_cp;
                    seq_have = 2'd0;
                    seq_need = 2'd0;
                    seq_cp   = '0;
                    clean_codepoint(cp);
                end else begin
                    seq_have++;
                end
            end else begin
                abandon_seq();
                open_seq(b);
            end
        end else begin
            open_seq(b);
        end
        if (last) begin
            abandon_seq();
            held_len = 0;
            put_result(8'h00, 1'b0, 1'b1, !name_started);
            name_started = 1'b0;
            ovf_flag     = 1'b0;
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].run_end = 1'b1;
        end
        foreach (step_q[k]) begin
            clean_q = {clean_q, step_q[k]};
        end
    endtask

    task automatic note_mismatch(input string what, input t_clean e);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t %s: expected %02h/%04b/%b got %02h/%04b/%b",
                     $realtime, what, e.ch, {e.ovf, e.empty, e.done, e.ok}, e.run_end,
                     i_m_tdata, i_m_tuser, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        t_clean e;
        if (!i_rst_n) begin
            seq_have     = 2'd0;
            seq_need     = 2'd0;
            seq_cp       = '0;
            name_started = 1'b0;
            held_len     = 0;
            ovf_flag     = 1'b0;
            o_fail_count = 0;
            clean_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (clean_q.size() == 0) begin
                    e = '0;
                    note_mismatch("unexpected result", e);
                end else begin
                    e = clean_q.pop_front();
                    if (i_m_tdata !== e.ch || i_m_tuser[0] !== e.ok
                        || i_m_tuser[1] !== e.done || i_m_tuser[2] !== e.empty
                        || i_m_tuser[3] !== e.ovf || i_m_tlast !== e.run_end) begin
                        note_mismatch("mismatch", e);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                sanitize_step(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = clean_q.size();
    end

endmodule

// ===== tb/sv/utf8_filename_sanitizer_tb.sv =====
// Top of the filename sanitizer testbench: clock, reset, name stimulus and verdict.
module utf8_filename_sanitizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 300;
    localparam logic [22:0] SEED_LAST = 23'h70_0000;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         sent;
    bit         gaps_on;
    bit         stalls_on;
    int         hold_reqs;
    int         holds_done;
    logic [7:0] name_q[$];

    utf8_filename_sanitizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    utf8_filename_sanitizer_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(input logic [7:0] b, input logic last);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        name_q = {name_q, b};
    endfunction

    task automatic add_token();
        logic [7:0]  reserved_chars[9];
        logic [15:0] bmp_bases[10];
        logic [15:0] cp16;
        logic [7:0]  lead;
        int          n;
        reserved_chars = '{ufs_pkg::CP_SLASH[7:0], ufs_pkg::CP_BSLASH[7:0],
                           ufs_pkg::CP_COLON[7:0], ufs_pkg::CP_STAR[7:0],
                           ufs_pkg::CP_QUEST[7:0], ufs_pkg::CP_QUOTE[7:0],
                           ufs_pkg::CP_LT[7:0], ufs_pkg::CP_GT[7:0],
                           ufs_pkg::CP_PIPE[7:0]};
        bmp_bases = '{16'h200B, 16'h2028, 16'h2060, 16'hFEFF, 16'hFE00, 16'h2190,
                      16'h2300, 16'h27BF, 16'h2B00, 16'hFFFD};
        case ($urandom_range(0, 11))
            0, 1, 2: put_byte(8'($urandom_range(8'h21, 8'h7E)));
            3: put_byte(reserved_chars[$urandom_range(0, 8)]);
            4: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
                repeat (n) put_byte($urandom_range(0, 1) ? ufs_pkg::CH_DOT : ufs_pkg::CH_SPACE);
            end
            5: begin
                put_byte({3'b110, 5'($urandom)});
                put_byte({2'b10, 6'($urandom)});
            end
            6: begin
                if ($urandom_range(0, 1)) begin
                    cp16 = bmp_bases[$urandom_range(0, 9)] + 16'($urandom_range(0, 3));
                end else begin
                    cp16 = 16'($urandom);
                end
                put_byte({4'b1110, cp16[15:12]});
                put_byte({2'b10, cp16[11:6]});
                put_byte({2'b10, cp16[5:0]});
            end
            7: begin
                put_byte({5'b11110, 3'($urandom)});
                put_byte($urandom_range(0, 1) ? 8'h9F : {2'b10, 6'($urandom)});
                put_byte({2'b10, 6'($urandom)});
                put_byte({2'b10, 6'($urandom)});
            end
            8: begin
                lead = 8'($urandom_range(8'hC0, 8'hF7));
                put_byte(lead);
                if (lead >= 8'hE0 && $urandom_range(0, 1)) begin
                    put_byte({2'b10, 6'($urandom)});
                end
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: put_byte(8'($urandom_range(8'h00, 8'h1F)));
                    1: put_byte(8'h7F);
                    default: begin
                        put_byte(8'hC2);
                        put_byte(8'($urandom_range(8'h80, 8'h9F)));
                    end
                endcase
            end
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_name();
        name_q.delete();
        repeat ($urandom_range(1, 8)) add_token();
        foreach (name_q[k]) begin
            send_request(name_q[k], k == name_q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        m_tready = 1'b0;
        holds_done = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (holds_done != hold_reqs) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] seed_bytes[$];
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_reqs = 0;
        sent      = 0;

        // leading run, reserved char, held run flushed by a two-byte char,
        // zero-width and emoji drops, bad lead, broken and truncated sequences
        seed_bytes = '{8'h20, 8'h2E, 8'h41, 8'h2F, 8'h20, 8'h2E, 8'hC3, 8'hA9,
                       8'hE2, 8'h80, 8'h8B, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF,
                       8'hE4, 8'h41, 8'h20, 8'h07, 8'hF4, 8'h00, 8'h80};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (seed_bytes[k]) begin
            send_request(seed_bytes[k], SEED_LAST[k]);
        end

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        while (sent < 140) send_name();

        // stall the output long enough to back up the input
        hold_reqs++;
        while (sent < 175) send_name();
        s_tvalid <= 1'b0;
        wait_drained();

        while (sent < 240) send_name();

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        while (sent < 295) send_name();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
